[src/sird_pkg.sv]
// Shared types and constants for the sorted interval read density block.
package sird_pkg;

  localparam int unsigned SIRD_POSITION_BITS      = 32;
  localparam int unsigned SIRD_READ_FRACTION_BITS = 8;
  localparam int unsigned SIRD_QUEUE_DEPTH        = 2;

  localparam int unsigned CHROM_W  = 8;
  localparam int unsigned IN_POS_W = 32;
  localparam int unsigned READS_W  = 24;
  localparam int unsigned SCORE_W  = 48;
  localparam int unsigned SCORE_FRAC_BITS = 16;
  localparam int unsigned DIV_W    = 64;

  localparam logic [1:0] KIND_ISLAND = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_EOR    = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [CHROM_W-1:0]  chromosome;
    logic [IN_POS_W-1:0] position;
    logic [IN_POS_W-1:0] span_end;
    logic [READS_W-1:0]  reads;
  } sird_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               by_end_of_data;
  } sird_result_t;

  // Job queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } sird_qstat_t;

endpackage

[src/sird_stream_if.sv]
// Valid/ready stream interfaces for island/record items and score results.
interface sird_in_if;
  import sird_pkg::*;
  logic       valid;
  logic       ready;
  sird_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sird_out_if;
  import sird_pkg::*;
  logic         valid;
  logic         ready;
  sird_result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/sird_front.sv]
// Front end: merge-join scan state, per-record compare and add, island close detection.
module sird_front #(
  parameter int unsigned POSITION_BITS = sird_pkg::SIRD_POSITION_BITS,
  parameter int unsigned JOB_W         = sird_pkg::SCORE_W + 2 * POSITION_BITS + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sird_in_if.sink               in_i,
  input  sird_pkg::sird_qstat_t qstat_i,
  output logic                  push_o,
  output logic [JOB_W-1:0]      job_o
);
  import sird_pkg::*;

  localparam int unsigned P    = POSITION_BITS;
  localparam int unsigned ExtW = IN_POS_W + P;

  logic [CHROM_W-1:0] held_chrom_q, held_chrom_d;
  logic [P-1:0]       held_pos_q, held_pos_d;
  logic [READS_W-1:0] held_reads_q, held_reads_d;
  logic               open_q, open_d;
  logic [CHROM_W-1:0] open_chrom_q, open_chrom_d;
  logic [P-1:0]       open_start_q, open_start_d;
  logic [P-1:0]       open_end_q, open_end_d;
  logic [SCORE_W-1:0] sum_q, sum_d;
  logic               exh_q, exh_d;

  logic [ExtW-1:0]    pos_ext, iend_ext;
  logic [P-1:0]       pos, iend;
  logic [CHROM_W-1:0] chrom;
  logic [READS_W-1:0] rd;
  logic [SCORE_W:0]   sum_add;
  logic               accept;
  logic               fin;
  logic               by_end;
  logic               seed;
  logic               in_win;
  logic               more;

  assign pos_ext  = ExtW'(in_i.data.position);
  assign iend_ext = ExtW'(in_i.data.span_end);
  assign pos      = pos_ext[P-1:0];
  assign iend     = iend_ext[P-1:0];
  assign chrom    = in_i.data.chromosome;
  assign rd       = in_i.data.reads;

  assign in_i.ready = !qstat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  assign seed    = (held_chrom_q == chrom) && (pos <= held_pos_q) && (iend >= held_pos_q);
  assign in_win  = (chrom == open_chrom_q) && (pos >= open_start_q) && (pos <= open_end_q);
  assign more    = ((pos < open_end_q) && (chrom == open_chrom_q)) || (chrom < open_chrom_q);
  assign sum_add = {1'b0, sum_q} + (SCORE_W + 1)'(rd);

  always_comb begin
    held_chrom_d = held_chrom_q;
    held_pos_d   = held_pos_q;
    held_reads_d = held_reads_q;
    open_d       = open_q;
    open_chrom_d = open_chrom_q;
    open_start_d = open_start_q;
    open_end_d   = open_end_q;
    sum_d        = sum_q;
    exh_d        = exh_q;
    fin          = 1'b0;
    by_end       = 1'b0;
    case (in_i.data.kind)
      KIND_ISLAND: begin
        open_d       = 1'b1;
        open_chrom_d = chrom;
        open_start_d = pos;
        open_end_d   = iend;
        sum_d        = seed ? SCORE_W'(held_reads_q) : '0;
        if (exh_q) begin
          held_chrom_d = '0;
          held_pos_d   = '0;
          held_reads_d = '0;
          fin          = 1'b1;
          by_end       = 1'b1;
          open_d       = 1'b0;
        end else if (iend == '0) begin
          // empty scan range: island closes at once, held record marks its chromosome
          held_chrom_d = chrom;
          held_pos_d   = '0;
          held_reads_d = '0;
          fin          = 1'b1;
          open_d       = 1'b0;
        end
      end
      KIND_RECORD: begin
        if (open_q && !exh_q) begin
          if (in_win) begin
            sum_d = sum_add[SCORE_W] ? {SCORE_W{1'b1}} : sum_add[SCORE_W-1:0];
          end
          if (!more) begin
            held_chrom_d = chrom;
            held_pos_d   = pos;
            held_reads_d = rd;
            fin          = 1'b1;
            open_d       = 1'b0;
          end
        end
      end
      KIND_EOR: begin
        exh_d = 1'b1;
        if (open_q) begin
          held_chrom_d = '0;
          held_pos_d   = '0;
          held_reads_d = '0;
          fin          = 1'b1;
          by_end       = 1'b1;
          open_d       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign push_o = accept && fin;
  assign job_o  = {sum_d, open_start_d, open_end_d, by_end};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_chrom_q <= '0;
      held_pos_q   <= '0;
      held_reads_q <= '0;
      open_q       <= 1'b0;
      open_chrom_q <= '0;
      open_start_q <= '0;
      open_end_q   <= '0;
      sum_q        <= '0;
      exh_q        <= 1'b0;
    end else if (accept) begin
      held_chrom_q <= held_chrom_d;
      held_pos_q   <= held_pos_d;
      held_reads_q <= held_reads_d;
      open_q       <= open_d;
      open_chrom_q <= open_chrom_d;
      open_start_q <= open_start_d;
      open_end_q   <= open_end_d;
      sum_q        <= sum_d;
      exh_q        <= exh_d;
    end
  end

endmodule

[src/sird_queue.sv]
// Short job queue between the scan front end and the scoring back end.
module sird_queue #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = sird_pkg::SIRD_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [WIDTH-1:0]      data_i,
  input  logic                  pop_i,
  output logic [WIDTH-1:0]      data_o,
  output sird_pkg::sird_qstat_t stat_o
);
  import sird_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[src/sird_back.sv]
// Back end: bit-serial restoring divider for island density and the result register.
module sird_back #(
  parameter int unsigned POSITION_BITS      = sird_pkg::SIRD_POSITION_BITS,
  parameter int unsigned READ_FRACTION_BITS = sird_pkg::SIRD_READ_FRACTION_BITS,
  parameter int unsigned JOB_W              = sird_pkg::SCORE_W + 2 * POSITION_BITS + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sird_pkg::sird_qstat_t qstat_i,
  input  logic [JOB_W-1:0]      job_i,
  output logic                  pop_o,
  sird_out_if.source            out_o
);
  import sird_pkg::*;

  localparam int unsigned P           = POSITION_BITS;
  localparam int unsigned ScaleShift  = SCORE_FRAC_BITS - READ_FRACTION_BITS;
  localparam int unsigned CntW        = $clog2(DIV_W);
  localparam logic [CntW-1:0] DivLast = CntW'(DIV_W - 1);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_WAIT = 3'b100
  } sird_back_state_e;

  sird_back_state_e state_q, state_d;

  logic [SCORE_W-1:0] j_sum;
  logic [P-1:0]       j_start, j_end;
  logic               j_by;

  logic [DIV_W-1:0]   num_q;
  logic [P:0]         den_q;
  logic [P:0]         rem_q;
  logic [CntW-1:0]    cnt_q;
  logic               bad_q;
  logic               by_q;

  logic [P+1:0]       trial, diff;
  logic               ge;
  logic               sat;
  logic               load_out;
  logic [SCORE_W-1:0] score;

  logic               out_valid_q;
  sird_result_t       out_data_q;

  assign j_sum   = job_i[JOB_W-1 -: SCORE_W];
  assign j_start = job_i[2*P : P+1];
  assign j_end   = job_i[P:1];
  assign j_by    = job_i[0];

  assign pop_o = (state_q == BK_IDLE) && !qstat_i.empty;

  // one quotient bit per cycle, dividend shifts out as quotient shifts in
  assign trial = {rem_q, num_q[DIV_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  assign sat      = |num_q[DIV_W-1:SCORE_W];
  assign score    = bad_q ? '0 : (sat ? {SCORE_W{1'b1}} : num_q[SCORE_W-1:0]);
  assign load_out = (state_q == BK_WAIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (pop_o) state_d = BK_DIV;
      BK_DIV:  if (cnt_q == DivLast) state_d = BK_WAIT;
      BK_WAIT: if (load_out) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        cnt_q <= '0;
      end else if (state_q == BK_DIV) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      num_q <= DIV_W'(j_sum) << ScaleShift;
      den_q <= (P+1)'(j_end) - (P+1)'(j_start) + (P+1)'(1);
      rem_q <= '0;
      bad_q <= (j_end < j_start);
      by_q  <= j_by;
    end else if (state_q == BK_DIV) begin
      num_q <= {num_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[P:0] : trial[P:0];
    end
    if (load_out) begin
      out_data_q.score          <= score;
      out_data_q.by_end_of_data <= by_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

[src/sorted_interval_read_density.sv]
// Top level of the sorted interval read density scorer.
//
//   channel | dir | payload                                          | transfer
//   in_i    | in  | kind, chromosome, position, span_end, reads      | valid && ready
//   out_o   | out | score, by_end_of_data                            | valid && ready
//
// Record and end-of-records items are taken one per cycle while the job queue is not
// full; the front end's compare and saturating add update the scan state per item.
// Each closed island is scored by the back end's bit-serial divider: a load from the
// queue, 64 quotient steps, then a transfer into the result register.
// in_i.ready drops only while the two-entry job queue is full; a stalled output holds
// the divider in its wait state and the queue absorbs islands that close meanwhile.
// Reset (rst_ni low, asynchronous) clears the scan state, the queue and the output valid.
module sorted_interval_read_density #(
  parameter int unsigned POSITION_BITS      = sird_pkg::SIRD_POSITION_BITS,
  parameter int unsigned READ_FRACTION_BITS = sird_pkg::SIRD_READ_FRACTION_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sird_in_if.sink    in_i,
  sird_out_if.source out_o
);
  import sird_pkg::*;

  localparam int unsigned JobW = SCORE_W + 2 * POSITION_BITS + 1;

  logic            push;
  logic            pop;
  logic [JobW-1:0] job_in;
  logic [JobW-1:0] job_out;
  sird_qstat_t     qstat;

  sird_front #(
    .POSITION_BITS (POSITION_BITS),
    .JOB_W         (JobW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push),
    .job_o   (job_in)
  );

  sird_queue #(
    .WIDTH (JobW),
    .DEPTH (SIRD_QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .pop_i  (pop),
    .data_o (job_out),
    .stat_o (qstat)
  );

  sird_back #(
    .POSITION_BITS      (POSITION_BITS),
    .READ_FRACTION_BITS (READ_FRACTION_BITS),
    .JOB_W              (JobW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .job_i   (job_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[src/sird_checker.sv]
// Port-level checks for the read density scorer, bound to the top level.
module sird_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [1:0]                  in_kind_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [sird_pkg::SCORE_W-1:0] out_score_i,
  input logic                        out_by_end_i
);
  import sird_pkg::*;

  logic eor_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eor_seen_q <= 1'b0;
    end else if (in_valid_i && in_ready_i && (in_kind_i == KIND_EOR)) begin
      eor_seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_score_i) && $stable(out_by_end_i))
    else $error("result changed or dropped while stalled");

  a_rst_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // an exhausted-scan result can only follow an accepted end-of-records transfer
  a_by_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_by_end_i |-> eor_seen_q)
    else $error("by_end_of_data set before end of records");

endmodule

bind sorted_interval_read_density sird_checker u_sird_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_kind_i    (in_i.data.kind),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_score_i  (out_o.data.score),
  .out_by_end_i (out_o.data.by_end_of_data)
);
